// File: src/kmdp_pkg.sv
// Shared types, codes and the key name table of the key macro parser.
`timescale 1ns / 1ps
package kmdp_pkg;

    localparam int MAX_STEPS_DEF    = 32;
    localparam int MAX_NAME_LEN_DEF = 16;
    localparam int NKEYS            = 87;
    localparam int NAME_CHARS       = 11;

    // Result kinds
    localparam logic [2:0] KIND_KEY   = 3'd0;
    localparam logic [2:0] KIND_DELAY = 3'd1;
    localparam logic [2:0] KIND_TEXT  = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_EMPTY     = 3'd1;
    localparam logic [2:0] ERR_UNTERM    = 3'd2;
    localparam logic [2:0] ERR_TOO_MANY  = 3'd3;
    localparam logic [2:0] ERR_EMPTY_SEG = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN   = 3'd5;
    localparam logic [2:0] ERR_NOT_MOD   = 3'd6;
    localparam logic [2:0] ERR_TOO_LONG  = 3'd7;

    // HID usage bases for single letters and digits
    localparam logic [7:0] USE_LETTER_A = 8'h04;
    localparam logic [7:0] USE_DIGIT_1  = 8'h1E;
    localparam logic [7:0] USE_DIGIT_0  = 8'h27;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  modifiers;
        logic [7:0]  usage;
        logic        usage_is_consumer;
        logic [15:0] delay_ms;
        logic [15:0] text_offset;
        logic [15:0] text_length;
        logic [2:0]  error_code;
        logic [5:0]  step_index;
        logic        final_res;
    } t_res;

    typedef struct packed {
        logic       hit;
        logic [7:0] usage;
        logic [7:0] mods;
        logic       cons;
    } t_key_hit;

    typedef struct packed {
        logic [8*NAME_CHARS-1:0] name;
        logic [7:0]              usage;
        logic [7:0]              mods;
        logic                    cons;
    } t_key_def;

    localparam t_key_def KEYS [NKEYS] = '{
        '{"f1", 8'h3A, 8'h00, 1'b0}, '{"f2", 8'h3B, 8'h00, 1'b0},
        '{"f3", 8'h3C, 8'h00, 1'b0}, '{"f4", 8'h3D, 8'h00, 1'b0},
        '{"f5", 8'h3E, 8'h00, 1'b0}, '{"f6", 8'h3F, 8'h00, 1'b0},
        '{"f7", 8'h40, 8'h00, 1'b0}, '{"f8", 8'h41, 8'h00, 1'b0},
        '{"f9", 8'h42, 8'h00, 1'b0}, '{"f10", 8'h43, 8'h00, 1'b0},
        '{"f11", 8'h44, 8'h00, 1'b0}, '{"f12", 8'h45, 8'h00, 1'b0},
        '{"f13", 8'h68, 8'h00, 1'b0}, '{"f14", 8'h69, 8'h00, 1'b0},
        '{"f15", 8'h6A, 8'h00, 1'b0}, '{"f16", 8'h6B, 8'h00, 1'b0},
        '{"f17", 8'h6C, 8'h00, 1'b0}, '{"f18", 8'h6D, 8'h00, 1'b0},
        '{"f19", 8'h6E, 8'h00, 1'b0}, '{"f20", 8'h6F, 8'h00, 1'b0},
        '{"f21", 8'h70, 8'h00, 1'b0}, '{"f22", 8'h71, 8'h00, 1'b0},
        '{"f23", 8'h72, 8'h00, 1'b0}, '{"f24", 8'h73, 8'h00, 1'b0},
        '{"enter", 8'h28, 8'h00, 1'b0}, '{"return", 8'h28, 8'h00, 1'b0},
        '{"esc", 8'h29, 8'h00, 1'b0}, '{"escape", 8'h29, 8'h00, 1'b0},
        '{"tab", 8'h2B, 8'h00, 1'b0}, '{"space", 8'h2C, 8'h00, 1'b0},
        '{"backspace", 8'h2A, 8'h00, 1'b0}, '{"bksp", 8'h2A, 8'h00, 1'b0},
        '{"delete", 8'h4C, 8'h00, 1'b0}, '{"del", 8'h4C, 8'h00, 1'b0},
        '{"insert", 8'h49, 8'h00, 1'b0}, '{"ins", 8'h49, 8'h00, 1'b0},
        '{"up", 8'h52, 8'h00, 1'b0}, '{"down", 8'h51, 8'h00, 1'b0},
        '{"left", 8'h50, 8'h00, 1'b0}, '{"right", 8'h4F, 8'h00, 1'b0},
        '{"home", 8'h4A, 8'h00, 1'b0}, '{"end", 8'h4D, 8'h00, 1'b0},
        '{"pageup", 8'h4B, 8'h00, 1'b0}, '{"pgup", 8'h4B, 8'h00, 1'b0},
        '{"pagedown", 8'h4E, 8'h00, 1'b0}, '{"pgdn", 8'h4E, 8'h00, 1'b0},
        '{"capslock", 8'h39, 8'h00, 1'b0}, '{"numlock", 8'h53, 8'h00, 1'b0},
        '{"scrolllock", 8'h47, 8'h00, 1'b0}, '{"printscreen", 8'h46, 8'h00, 1'b0},
        '{"prtsc", 8'h46, 8'h00, 1'b0}, '{"pause", 8'h48, 8'h00, 1'b0},
        '{"minus", 8'h2D, 8'h00, 1'b0}, '{"equal", 8'h2E, 8'h00, 1'b0},
        '{"lbracket", 8'h2F, 8'h00, 1'b0}, '{"rbracket", 8'h30, 8'h00, 1'b0},
        '{"backslash", 8'h31, 8'h00, 1'b0}, '{"semicolon", 8'h33, 8'h00, 1'b0},
        '{"quote", 8'h34, 8'h00, 1'b0}, '{"grave", 8'h35, 8'h00, 1'b0},
        '{"comma", 8'h36, 8'h00, 1'b0}, '{"period", 8'h37, 8'h00, 1'b0},
        '{"slash", 8'h38, 8'h00, 1'b0},
        '{"ctrl", 8'h00, 8'h01, 1'b0}, '{"lctrl", 8'h00, 8'h01, 1'b0},
        '{"shift", 8'h00, 8'h02, 1'b0}, '{"lshift", 8'h00, 8'h02, 1'b0},
        '{"alt", 8'h00, 8'h04, 1'b0}, '{"lalt", 8'h00, 8'h04, 1'b0},
        '{"gui", 8'h00, 8'h08, 1'b0}, '{"lgui", 8'h00, 8'h08, 1'b0},
        '{"win", 8'h00, 8'h08, 1'b0}, '{"cmd", 8'h00, 8'h08, 1'b0},
        '{"super", 8'h00, 8'h08, 1'b0}, '{"rctrl", 8'h00, 8'h10, 1'b0},
        '{"rshift", 8'h00, 8'h20, 1'b0}, '{"ralt", 8'h00, 8'h40, 1'b0},
        '{"altgr", 8'h00, 8'h40, 1'b0}, '{"rgui", 8'h00, 8'h80, 1'b0},
        '{"rwin", 8'h00, 8'h80, 1'b0},
        // Some media names are spelled as two joined pieces
        '{{"play_", "pause"}, 8'hCD, 8'h00, 1'b1}, '{"stop", 8'hB7, 8'h00, 1'b1},
        '{{"next_", "track"}, 8'hB5, 8'h00, 1'b1},
        '{{"prev_", "track"}, 8'hB6, 8'h00, 1'b1},
        '{"vol_up", 8'hE9, 8'h00, 1'b1}, '{{"vol_", "down"}, 8'hEA, 8'h00, 1'b1},
        '{"mute", 8'hE2, 8'h00, 1'b1}
    };

    // Count name characters; names are right-justified, so count nonzero bytes
    function automatic logic [4:0] key_len(input int i);
        logic [4:0] n;
        n = '0;
        for (int p = 0; p < NAME_CHARS; p++) begin
            if (KEYS[i].name[8*p +: 8] != 8'h00) n = n + 5'd1;
        end
        return n;
    endfunction

    // Character p of key i, zero past the end of its name
    function automatic logic [7:0] name_char(input int i, input int p);
        int len;
        len = int'(key_len(i));
        if (p < len) return KEYS[i].name[8*(len-1-p) +: 8];
        return 8'h00;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return c + 8'd32;
        return c;
    endfunction

endpackage

// File: src/kmdp_if.sv
// Request channel interfaces of the key macro parser: input bytes and step results.
`timescale 1ns / 1ps
interface kmdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, ch, last, input ready);
    modport sink   (input valid, ch, last, output ready);
endinterface

interface kmdp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  modifiers;
    logic [7:0]  usage;
    logic        usage_is_consumer;
    logic [15:0] delay_ms;
    logic [15:0] text_offset;
    logic [15:0] text_length;
    logic [2:0]  error_code;
    logic [5:0]  step_index;
    logic        final_res;

    modport source (output valid, kind, modifiers, usage, usage_is_consumer, delay_ms,
                    text_offset, text_length, error_code, step_index, final_res,
                    input ready);
    modport sink   (input valid, kind, modifiers, usage, usage_is_consumer, delay_ms,
                    text_offset, text_length, error_code, step_index, final_res,
                    output ready);
endinterface

// File: src/key_macro_dsl_parser.sv
// Top level of the key macro parser: byte stream in, one step result per finished step.
//
// Usage:
//   i_in carries one byte of a macro string per request (ch, last); a zero byte
//   ends the string, and last marks its final byte. o_res carries one result
//   per finished step: key combo, delay, quoted text, error, or end of string.
//   final_res is set on the last result of a string.
// Latency and throughput:
//   One byte is taken per cycle while the output register is free. A byte that
//   finishes a step shows its result on o_res in the cycle after it is accepted.
//   All parsing of a byte, including the 87-entry key name match, is combinational.
// Stall:
//   The output register holds a result until it is taken; a new byte is still
//   taken while the register is empty or being emptied in the same cycle.
// Reset:
//   i_rst_n clears the parser to the start of a sequence and empties the
//   output register. After an error or a zero byte, bytes are dropped until
//   the byte marked last, which returns the parser to its reset state.
`timescale 1ns / 1ps
module key_macro_dsl_parser #(
    parameter int MAX_STEPS    = kmdp_pkg::MAX_STEPS_DEF,
    parameter int MAX_NAME_LEN = kmdp_pkg::MAX_NAME_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kmdp_in_if.sink           i_in,
    kmdp_out_if.source        o_res
);

    localparam int NK = kmdp_pkg::NKEYS;

    typedef enum logic [1:0] {
        PH_START, PH_BETWEEN, PH_TEXT, PH_TOKEN
    } t_phase;

    typedef enum logic [2:0] {
        DS_NONE, DS_DIGITS, DS_M, DS_MS, DS_BAD
    } t_dshape;

    // Parser state
    t_phase         r_phase,  c_phase,  n_phase;
    logic [15:0]    r_pos,    c_pos,    n_pos;
    logic [5:0]     r_steps,  c_steps,  n_steps;
    logic [15:0]    r_tbeg,   c_tbeg,   n_tbeg;
    logic           r_bslash, c_bslash, n_bslash;
    logic [15:0]    r_dval,   c_dval,   n_dval;
    t_dshape        r_dshape, c_dshape, n_dshape;
    logic [NK-1:0]  r_cand,   c_cand,   n_cand;
    logic [4:0]     r_seglen, c_seglen, n_seglen;
    logic [7:0]     r_first,  c_first,  n_first;
    logic [7:0]     r_mods,   c_mods,   n_mods;
    logic           r_plus,   c_plus,   n_plus;
    logic           r_err,    n_err;

    // Output register
    logic             r_out_valid;
    kmdp_pkg::t_res   r_out;

    logic             in_acc;
    logic             blank;
    logic             active;
    logic             fresh;
    logic [7:0]       lc;
    logic [4:0]       b_seglen;
    logic [NK-1:0]    m_keep;
    logic [19:0]      dig_sum;
    logic             c_got;
    logic             c_tok_end;
    kmdp_pkg::t_res   c_res;
    kmdp_pkg::t_res   te_res;
    logic             te_ok;
    kmdp_pkg::t_res   ee_res;
    logic             got;
    kmdp_pkg::t_res   res;
    kmdp_pkg::t_key_hit hit_pre;
    kmdp_pkg::t_key_hit hit_post;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign blank      = (i_in.ch == " ") || (i_in.ch == 8'h09);
    assign active     = !r_err && (i_in.ch != 8'h00) && (r_pos != 16'hFFFF);
    assign fresh      = (r_phase == PH_START) || (r_phase == PH_BETWEEN);
    assign lc         = kmdp_pkg::to_lower(i_in.ch);
    assign b_seglen   = fresh ? 5'd0 : r_seglen;
    assign dig_sum    = 20'(fresh ? 16'd0 : r_dval) * 20'd10 + 20'(i_in.ch - 8'("0"));

    // Narrow the candidate mask by the byte at the current name position
    always_comb begin
        for (int i = 0; i < NK; i++) begin
            m_keep[i] = 1'b0;
            for (int p = 0; p < kmdp_pkg::NAME_CHARS; p++) begin
                if (b_seglen == 5'(p) && kmdp_pkg::name_char(i, p) == lc) m_keep[i] = 1'b1;
            end
        end
    end

    // Look up the segment before this byte (closing plus) and after it (token end)
    kmdp_key_find #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_find_pre (
        .i_cand       (r_cand),
        .i_seg_len    (r_seglen),
        .i_first_char (r_first),
        .o_hit        (hit_pre)
    );

    kmdp_key_find #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_find_post (
        .i_cand       (c_cand),
        .i_seg_len    (c_seglen),
        .i_first_char (c_first),
        .o_hit        (hit_post)
    );

    // Consume one nonzero byte
    always_comb begin
        c_phase   = r_phase;
        c_pos     = r_pos;
        c_steps   = r_steps;
        c_tbeg    = r_tbeg;
        c_bslash  = r_bslash;
        c_dval    = r_dval;
        c_dshape  = r_dshape;
        c_cand    = r_cand;
        c_seglen  = r_seglen;
        c_first   = r_first;
        c_mods    = r_mods;
        c_plus    = r_plus;
        c_got     = 1'b0;
        c_tok_end = 1'b0;
        c_res     = '0;
        if (active) begin
            c_pos = r_pos + 16'd1;
            if (r_phase == PH_TEXT) begin
                if (i_in.ch == "\"" && !r_bslash) begin
                    c_got             = 1'b1;
                    c_res.kind        = kmdp_pkg::KIND_TEXT;
                    c_res.text_offset = r_tbeg;
                    c_res.text_length = r_pos - r_tbeg;
                    c_res.step_index  = r_steps;
                    c_steps           = r_steps + 6'd1;
                    c_phase           = PH_BETWEEN;
                end else begin
                    c_bslash = (i_in.ch == "\\");
                end
            end else if (r_phase == PH_TOKEN && blank) begin
                c_tok_end = 1'b1;
            end else if (fresh && blank) begin
                c_got = 1'b0;
            end else if (fresh && r_steps >= 6'(MAX_STEPS)) begin
                c_got            = 1'b1;
                c_res.kind       = kmdp_pkg::KIND_ERROR;
                c_res.error_code = kmdp_pkg::ERR_TOO_MANY;
                c_res.step_index = r_steps;
            end else if (fresh && i_in.ch == "\"") begin
                c_phase  = PH_TEXT;
                c_tbeg   = r_pos + 16'd1;
                c_bslash = 1'b0;
            end else begin
                // Token byte: open a new token if needed, then track delay shape
                if (fresh) begin
                    c_phase  = PH_TOKEN;
                    c_dval   = '0;
                    c_dshape = DS_NONE;
                    c_mods   = '0;
                    c_plus   = 1'b0;
                    c_cand   = '1;
                    c_seglen = '0;
                    c_first  = '0;
                end
                if (i_in.ch >= "0" && i_in.ch <= "9") begin
                    if (c_dshape == DS_NONE || c_dshape == DS_DIGITS) begin
                        if (dig_sum[19:16] != 4'd0) begin
                            c_dshape = DS_BAD;
                        end else begin
                            c_dval   = dig_sum[15:0];
                            c_dshape = DS_DIGITS;
                        end
                    end else begin
                        c_dshape = DS_BAD;
                    end
                end else if (lc == "m") begin
                    c_dshape = (c_dshape == DS_DIGITS) ? DS_M : DS_BAD;
                end else if (lc == "s") begin
                    c_dshape = (c_dshape == DS_M) ? DS_MS : DS_BAD;
                end else begin
                    c_dshape = DS_BAD;
                end
                if (i_in.ch == "+") begin
                    c_plus = 1'b1;
                    if (c_seglen == 5'd0) begin
                        c_got            = 1'b1;
                        c_res.kind       = kmdp_pkg::KIND_ERROR;
                        c_res.error_code = kmdp_pkg::ERR_EMPTY_SEG;
                        c_res.step_index = r_steps;
                    end else if (!hit_pre.hit) begin
                        c_got            = 1'b1;
                        c_res.kind       = kmdp_pkg::KIND_ERROR;
                        c_res.error_code = kmdp_pkg::ERR_UNKNOWN;
                        c_res.step_index = r_steps;
                    end else if (hit_pre.mods == 8'h00) begin
                        c_got            = 1'b1;
                        c_res.kind       = kmdp_pkg::KIND_ERROR;
                        c_res.error_code = kmdp_pkg::ERR_NOT_MOD;
                        c_res.step_index = r_steps;
                    end else begin
                        c_mods   = c_mods | hit_pre.mods;
                        c_cand   = '1;
                        c_seglen = '0;
                        c_first  = '0;
                    end
                end else begin
                    if (c_seglen == 5'd0) c_first = i_in.ch;
                    c_cand = c_cand & m_keep;
                    if (c_seglen != 5'd31) c_seglen = c_seglen + 5'd1;
                end
            end
        end
    end

    // Close the current token into a delay or key step, or an unknown-key error
    always_comb begin
        te_res            = '0;
        te_ok             = 1'b1;
        te_res.step_index = c_steps;
        if (c_dshape == DS_MS) begin
            te_res.kind     = kmdp_pkg::KIND_DELAY;
            te_res.delay_ms = c_dval;
        end else if (c_seglen != 5'd0 && !hit_post.hit) begin
            te_ok             = 1'b0;
            te_res.kind       = kmdp_pkg::KIND_ERROR;
            te_res.error_code = kmdp_pkg::ERR_UNKNOWN;
        end else begin
            te_res.kind      = kmdp_pkg::KIND_KEY;
            te_res.modifiers = c_mods;
            if (c_seglen != 5'd0) begin
                if (hit_post.mods != 8'h00) begin
                    if (c_plus) te_res.modifiers = c_mods | hit_post.mods;
                end else begin
                    te_res.usage             = hit_post.usage;
                    te_res.usage_is_consumer = hit_post.cons;
                end
            end
        end
    end

    // End of string result for the phase left after this byte
    always_comb begin
        ee_res            = '0;
        ee_res.step_index = c_steps;
        case (c_phase)
            PH_START: begin
                ee_res.kind       = kmdp_pkg::KIND_ERROR;
                ee_res.error_code = kmdp_pkg::ERR_EMPTY;
            end
            PH_TEXT: begin
                ee_res.kind       = kmdp_pkg::KIND_ERROR;
                ee_res.error_code = kmdp_pkg::ERR_UNTERM;
            end
            PH_TOKEN: begin
                ee_res = te_res;
            end
            default: begin
                ee_res.kind = kmdp_pkg::KIND_END;
            end
        endcase
    end

    // Select the result and next state; finish on an error, a zero byte or the last byte; reset on the last byte
    always_comb begin
        logic fin;
        logic clear;
        n_phase  = c_phase;
        n_pos    = c_pos;
        n_steps  = c_steps;
        n_tbeg   = c_tbeg;
        n_bslash = c_bslash;
        n_dval   = c_dval;
        n_dshape = c_dshape;
        n_cand   = c_cand;
        n_seglen = c_seglen;
        n_first  = c_first;
        n_mods   = c_mods;
        n_plus   = c_plus;
        n_err    = r_err;
        got      = 1'b0;
        res      = '0;
        fin      = 1'b0;
        clear    = 1'b0;
        if (r_err) begin
            clear = i_in.last;
        end else if (i_in.ch == 8'h00) begin
            got = 1'b1;
            res = ee_res;
            fin = 1'b1;
        end else if (r_pos == 16'hFFFF) begin
            got              = 1'b1;
            res.kind         = kmdp_pkg::KIND_ERROR;
            res.error_code   = kmdp_pkg::ERR_TOO_LONG;
            res.step_index   = r_steps;
            fin              = 1'b1;
        end else begin
            if (c_tok_end) begin
                got = 1'b1;
                res = te_res;
                if (te_ok) begin
                    n_steps = c_steps + 6'd1;
                    n_phase = PH_BETWEEN;
                end
            end else begin
                got = c_got;
                res = c_res;
            end
            fin = got && (res.kind == kmdp_pkg::KIND_ERROR);
            if (!fin && i_in.last) begin
                if (!got) begin
                    got = 1'b1;
                    res = ee_res;
                end
                fin = 1'b1;
            end
        end
        if (fin) begin
            res.final_res = 1'b1;
            if (i_in.last) clear = 1'b1;
            else n_err = 1'b1;
        end
        if (clear) begin
            n_phase  = PH_START;
            n_pos    = '0;
            n_steps  = '0;
            n_tbeg   = '0;
            n_bslash = 1'b0;
            n_dval   = '0;
            n_dshape = DS_NONE;
            n_cand   = '1;
            n_seglen = '0;
            n_first  = '0;
            n_mods   = '0;
            n_plus   = 1'b0;
            n_err    = 1'b0;
        end
    end

    // Hold parser state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_pos       <= '0;
            r_steps     <= '0;
            r_tbeg      <= '0;
            r_bslash    <= 1'b0;
            r_dval      <= '0;
            r_dshape    <= DS_NONE;
            r_cand      <= '1;
            r_seglen    <= '0;
            r_first     <= '0;
            r_mods      <= '0;
            r_plus      <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (in_acc) begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_steps  <= n_steps;
                r_tbeg   <= n_tbeg;
                r_bslash <= n_bslash;
                r_dval   <= n_dval;
                r_dshape <= n_dshape;
                r_cand   <= n_cand;
                r_seglen <= n_seglen;
                r_first  <= n_first;
                r_mods   <= n_mods;
                r_plus   <= n_plus;
                r_err    <= n_err;
            end
            if (in_acc && got) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.kind              = r_out.kind;
    assign o_res.modifiers         = r_out.modifiers;
    assign o_res.usage             = r_out.usage;
    assign o_res.usage_is_consumer = r_out.usage_is_consumer;
    assign o_res.delay_ms          = r_out.delay_ms;
    assign o_res.text_offset       = r_out.text_offset;
    assign o_res.text_length       = r_out.text_length;
    assign o_res.error_code        = r_out.error_code;
    assign o_res.step_index        = r_out.step_index;
    assign o_res.final_res         = r_out.final_res;

`ifndef ASSERT_OFF
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");
    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_steps <= 6'(MAX_STEPS))
        else $error("step count beyond limit");
    a_error_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.kind == kmdp_pkg::KIND_ERROR |-> o_res.final_res)
        else $error("error result not final");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output register");
`endif

endmodule

// File: src/kmdp_key_find.sv
// Key name lookup: resolves a segment to its HID usage from the candidate mask.
`timescale 1ns / 1ps
module kmdp_key_find #(
    parameter int MAX_NAME_LEN = kmdp_pkg::MAX_NAME_LEN_DEF
) (
    input  logic [kmdp_pkg::NKEYS-1:0] i_cand,
    input  logic [4:0]                 i_seg_len,
    input  logic [7:0]                 i_first_char,
    output kmdp_pkg::t_key_hit         o_hit
);

    logic [7:0] lc;

    assign lc = kmdp_pkg::to_lower(i_first_char);

    // Pick single letters and digits first, then the lowest matching table entry
    always_comb begin
        o_hit = '0;
        if (i_seg_len == 5'd1 && lc >= "a" && lc <= "z") begin
            o_hit.hit   = 1'b1;
            o_hit.usage = kmdp_pkg::USE_LETTER_A + (lc - 8'("a"));
        end else if (i_seg_len == 5'd1 && i_first_char >= "0" && i_first_char <= "9") begin
            o_hit.hit   = 1'b1;
            o_hit.usage = (i_first_char == "0") ? kmdp_pkg::USE_DIGIT_0
                        : kmdp_pkg::USE_DIGIT_1 + (i_first_char - 8'("1"));
        end else if (i_seg_len <= 5'(MAX_NAME_LEN)) begin
            for (int i = kmdp_pkg::NKEYS - 1; i >= 0; i--) begin
                if (i_cand[i] && kmdp_pkg::key_len(i) == i_seg_len) begin
                    o_hit.hit   = 1'b1;
                    o_hit.usage = kmdp_pkg::KEYS[i].usage;
                    o_hit.mods  = kmdp_pkg::KEYS[i].mods;
                    o_hit.cons  = kmdp_pkg::KEYS[i].cons;
                end
            end
        end
    end

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the key macro parser: directed macros, then random macros.
`timescale 1ns / 1ps
module testbench;

    localparam int STEP_LIMIT   = kmdp_pkg::MAX_STEPS_DEF;
    localparam int NAME_LIMIT   = kmdp_pkg::MAX_NAME_LEN_DEF;
    localparam int RAND_BYTES   = 1220;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int FIRST_MOD    = 63;
    localparam int LAST_MOD     = 79;

    typedef enum logic [1:0] {P_SEQ_START, P_GAP, P_TEXT, P_TOKEN} t_parse_phase;
    typedef enum logic [2:0] {D_NONE, D_DIGITS, D_M, D_MS, D_BAD} t_delay_shape;

    // Expected final result of a macro: checked only where typed in
    typedef struct {
        bit         typed;
        logic [2:0] kind;
        logic [2:0] err;
    } t_final_chk;

    logic clk;
    logic rst_n;

    kmdp_in_if  in_if();
    kmdp_out_if res_if();

    key_macro_dsl_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    // Parser shadow state
    t_parse_phase pm_phase;
    logic [15:0]  pm_pos;
    logic [5:0]   pm_steps;
    logic [15:0]  pm_text_beg;
    logic         pm_escape;
    logic [15:0]  pm_delay;
    t_delay_shape pm_shape;
    logic [kmdp_pkg::NKEYS-1:0] pm_cand;
    logic [4:0]   pm_seglen;
    logic [7:0]   pm_seg0;
    logic [7:0]   pm_mods;
    logic         pm_has_plus;
    logic         pm_dropping;
    kmdp_pkg::t_res pm_res;

    kmdp_pkg::t_res step_q[$];
    t_final_chk   final_q[$];
    logic [8:0]   byte_q[$];
    byte unsigned mac[$];

    int  idle_pct, stall_pct;
    bit  hold_req;
    int  hold_cnt;
    bit  taken;
    int  errors, n_results, n_bytes, n_macros, cycles;
    int  kind_seen[5];
    bit  err_seen[8];

    // Key table helpers: names sit right-justified in the name vector
    function automatic int name_len(input int i);
        int n;
        n = 0;
        for (int p = 0; p < kmdp_pkg::NAME_CHARS; p++)
            if (kmdp_pkg::KEYS[i].name[8*p +: 8] != 8'h00) n++;
        return n;
    endfunction

    function automatic logic [7:0] name_at(input int i, input int p);
        int n;
        n = name_len(i);
        return kmdp_pkg::KEYS[i].name[8*(n-1-p) +: 8];
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void parser_clear();
        pm_phase    = P_SEQ_START;
        pm_pos      = '0;
        pm_steps    = '0;
        pm_text_beg = '0;
        pm_escape   = 1'b0;
        pm_delay    = '0;
        pm_shape    = D_NONE;
        pm_cand     = '1;
        pm_seglen   = '0;
        pm_seg0     = '0;
        pm_mods     = '0;
        pm_has_plus = 1'b0;
        pm_dropping = 1'b0;
    endfunction

    function automatic void open_segment();
        pm_cand   = '1;
        pm_seglen = '0;
        pm_seg0   = '0;
    endfunction

    function automatic void open_step(input logic [2:0] kind);
        pm_res = '0;
        pm_res.kind = kind;
        pm_res.step_index = pm_steps;
    endfunction

    function automatic bit raise(input logic [2:0] code);
        open_step(kmdp_pkg::KIND_ERROR);
        pm_res.error_code = code;
        return 1'b1;
    endfunction

    // Resolve the current segment to a key
    function automatic bit match_segment(output logic [7:0] use_c, output logic [7:0] mod_c,
                                         output logic cons_c);
        logic [7:0] l;
        use_c = '0; mod_c = '0; cons_c = 1'b0;
        if (pm_seglen == 5'd1) begin
            l = fold(pm_seg0);
            if (l >= "a" && l <= "z") begin
                use_c = kmdp_pkg::USE_LETTER_A + (l - 8'h61);
                return 1'b1;
            end
            if (pm_seg0 >= "0" && pm_seg0 <= "9") begin
                use_c = (pm_seg0 == "0") ? kmdp_pkg::USE_DIGIT_0
                      : kmdp_pkg::USE_DIGIT_1 + (pm_seg0 - 8'h31);
                return 1'b1;
            end
        end
        if (pm_seglen > NAME_LIMIT) return 1'b0;
        for (int i = 0; i < kmdp_pkg::NKEYS; i++) begin
            if (pm_cand[i] && name_len(i) == pm_seglen) begin
                use_c  = kmdp_pkg::KEYS[i].usage;
                mod_c  = kmdp_pkg::KEYS[i].mods;
                cons_c = kmdp_pkg::KEYS[i].cons;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit token_byte(input logic [7:0] c);
        logic [31:0] v;
        logic [7:0]  u, m;
        logic        k;
        int          idx, n;
        // Track whether the token still reads as a delay
        if (c >= "0" && c <= "9") begin
            if (pm_shape == D_NONE || pm_shape == D_DIGITS) begin
                v = 32'(pm_delay) * 10 + 32'(c - 8'h30);
                if (v > 65535) pm_shape = D_BAD;
                else begin
                    pm_delay = v[15:0];
                    pm_shape = D_DIGITS;
                end
            end else pm_shape = D_BAD;
        end else if (fold(c) == "m") begin
            pm_shape = (pm_shape == D_DIGITS) ? D_M : D_BAD;
        end else if (fold(c) == "s") begin
            pm_shape = (pm_shape == D_M) ? D_MS : D_BAD;
        end else pm_shape = D_BAD;

        // Close a combo segment
        if (c == "+") begin
            pm_has_plus = 1'b1;
            if (pm_seglen == 0) return raise(kmdp_pkg::ERR_EMPTY_SEG);
            if (!match_segment(u, m, k)) return raise(kmdp_pkg::ERR_UNKNOWN);
            if (m == 0) return raise(kmdp_pkg::ERR_NOT_MOD);
            pm_mods |= m;
            open_segment();
            return 1'b0;
        end
        // Narrow the name candidates
        idx = pm_seglen;
        if (idx == 0) pm_seg0 = c;
        for (int i = 0; i < kmdp_pkg::NKEYS; i++) begin
            n = name_len(i);
            if (idx >= n || fold(name_at(i, idx)) != fold(c)) pm_cand[i] = 1'b0;
        end
        if (pm_seglen < 5'd31) pm_seglen++;
        return 1'b0;
    endfunction

    function automatic bit token_done();
        logic [7:0] u, m;
        logic       k;
        u = '0; m = '0; k = 1'b0;
        pm_phase = P_GAP;
        if (pm_shape == D_MS) begin
            open_step(kmdp_pkg::KIND_DELAY);
            pm_res.delay_ms = pm_delay;
            pm_steps++;
            return 1'b1;
        end
        if (pm_seglen != 0) begin
            if (!match_segment(u, m, k)) return raise(kmdp_pkg::ERR_UNKNOWN);
            if (m != 0) begin
                if (pm_has_plus) pm_mods |= m;
                u = '0; k = 1'b0;
            end
        end
        open_step(kmdp_pkg::KIND_KEY);
        pm_res.modifiers = pm_mods;
        pm_res.usage = u;
        pm_res.usage_is_consumer = k;
        pm_steps++;
        return 1'b1;
    endfunction

    function automatic bit string_done();
        case (pm_phase)
            P_SEQ_START: return raise(kmdp_pkg::ERR_EMPTY);
            P_TEXT:      return raise(kmdp_pkg::ERR_UNTERM);
            P_TOKEN:     return token_done();
            default: begin
                open_step(kmdp_pkg::KIND_END);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic bit take_byte(input logic [7:0] c);
        bit blank;
        blank = (c == " " || c == 8'h09);
        if (pm_phase == P_TEXT) begin
            if (c == 8'h22 && !pm_escape) begin
                open_step(kmdp_pkg::KIND_TEXT);
                pm_res.text_offset = pm_text_beg;
                pm_res.text_length = pm_pos - pm_text_beg;
                pm_steps++;
                pm_phase = P_GAP;
                return 1'b1;
            end
            pm_escape = (c == 8'h5C);
            return 1'b0;
        end
        if (pm_phase == P_TOKEN) begin
            if (blank) return token_done();
            return token_byte(c);
        end
        if (blank) return 1'b0;
        if (pm_steps >= STEP_LIMIT) return raise(kmdp_pkg::ERR_TOO_MANY);
        if (c == 8'h22) begin
            pm_phase = P_TEXT;
            pm_text_beg = pm_pos + 16'd1;
            pm_escape = 1'b0;
            return 1'b0;
        end
        pm_phase = P_TOKEN;
        pm_delay = '0;
        pm_shape = D_NONE;
        pm_mods = '0;
        pm_has_plus = 1'b0;
        open_segment();
        return token_byte(c);
    endfunction

    // Work out the step result caused by one accepted byte
    function automatic bit parse_byte(input logic [7:0] c, input logic lst);
        bit got, fin;
        fin = 1'b0;
        if (pm_dropping) begin
            if (lst) parser_clear();
            return 1'b0;
        end
        if (c == 8'h00) begin
            got = string_done();
            fin = 1'b1;
        end else if (pm_pos == 16'hFFFF) begin
            got = raise(kmdp_pkg::ERR_TOO_LONG);
            fin = 1'b1;
        end else begin
            got = take_byte(c);
            pm_pos++;
            if (got && pm_res.kind == kmdp_pkg::KIND_ERROR) fin = 1'b1;
            if (!fin && lst) begin
                if (!got) got = string_done();
                fin = 1'b1;
            end
        end
        if (fin) begin
            pm_res.final_res = 1'b1;
            if (lst) parser_clear();
            else pm_dropping = 1'b1;
        end
        return got;
    endfunction

    function automatic void cmp_field(input string nm, input int e, input int a);
        if (e != a) begin
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $realtime, nm, e, a);
        end
    endfunction

    // Clock and reset
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.ch = '0;
        in_if.last = 1'b0;
        res_if.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
    end

    // Sample both channels: check the result, then predict from the new byte
    always @(posedge clk) begin
        taken = in_if.valid && in_if.ready;
        if (rst_n && res_if.valid && res_if.ready) begin
            kmdp_pkg::t_res e;
            t_final_chk f;
            n_results++;
            if (res_if.kind < 5) kind_seen[res_if.kind]++;
            if (res_if.kind == kmdp_pkg::KIND_ERROR) err_seen[res_if.error_code] = 1'b1;
            if (step_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result kind %0d", $realtime, res_if.kind);
            end else begin
                e = step_q.pop_front();
                cmp_field("kind", e.kind, res_if.kind);
                cmp_field("modifiers", e.modifiers, res_if.modifiers);
                cmp_field("usage", e.usage, res_if.usage);
                cmp_field("usage_is_consumer", e.usage_is_consumer, res_if.usage_is_consumer);
                cmp_field("delay_ms", e.delay_ms, res_if.delay_ms);
                cmp_field("text_offset", e.text_offset, res_if.text_offset);
                cmp_field("text_length", e.text_length, res_if.text_length);
                cmp_field("error_code", e.error_code, res_if.error_code);
                cmp_field("step_index", e.step_index, res_if.step_index);
                cmp_field("final_res", e.final_res, res_if.final_res);
            end
            // Typed final outcome of a directed macro
            if (res_if.final_res && final_q.size() != 0) begin
                f = final_q.pop_front();
                if (f.typed) begin
                    cmp_field("final kind", f.kind, res_if.kind);
                    cmp_field("final error_code", f.err, res_if.error_code);
                end
            end
        end
        if (rst_n && taken) begin
            n_bytes++;
            if (parse_byte(in_if.ch, in_if.last)) step_q.push_back(pm_res);
        end
    end

    // Drive bytes; hold a request until it is taken
    always @(negedge clk) begin
        if (rst_n && !(in_if.valid && !taken)) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                logic [8:0] b;
                b = byte_q.pop_front();
                in_if.ch = b[7:0];
                in_if.last = b[8];
                in_if.valid = 1'b1;
            end else begin
                in_if.valid = 1'b0;
            end
        end
    end

    // Receiver stalls, with one long hold-off on request
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_cnt > 0) begin
                hold_cnt--;
                res_if.ready = 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Timeout
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Queue the macro under construction, last on its final byte
    task automatic send_macro(input bit typed, input logic [2:0] kind, input logic [2:0] err);
        t_final_chk f;
        for (int i = 0; i < mac.size(); i++)
            byte_q.push_back({(i == mac.size() - 1), 8'(mac[i])});
        f.typed = typed; f.kind = kind; f.err = err;
        final_q.push_back(f);
        n_macros++;
        mac.delete();
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) mac.push_back(s[i]);
    endtask

    function automatic byte unsigned any_case(input byte unsigned c);
        if (fold(c) >= "a" && fold(c) <= "z" && $urandom_range(1)) return c ^ 8'h20;
        return c;
    endfunction

    task automatic put_key_name(input int i);
        for (int p = 0; p < name_len(i); p++) mac.push_back(any_case(name_at(i, p)));
    endtask

    // One random step of a well-formed macro, sometimes broken
    task automatic put_random_step();
        int sel, n;
        byte unsigned c;
        sel = $urandom_range(99);
        if (sel < 25) begin
            mac.push_back(8'h22);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(1, 255));
                if (c == 8'h22) mac.push_back(8'h5C);
                mac.push_back(c);
            end
            if ($urandom_range(9) != 0) mac.push_back(8'h22);
        end else if (sel < 45) begin
            n = ($urandom_range(9) == 0) ? 6 : $urandom_range(1, 5);
            for (int i = 0; i < n; i++) mac.push_back(8'("0" + $urandom_range(9)));
            if ($urandom_range(9) != 0) mac.push_back(any_case("m"));
            if ($urandom_range(9) != 0) mac.push_back(any_case("s"));
        end else if (sel < 90) begin
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
                put_key_name($urandom_range(FIRST_MOD, LAST_MOD));
                mac.push_back("+");
            end
            case ($urandom_range(9))
                0: ;
                1: mac.push_back("+");
                2: mac.push_back(any_case(8'("a" + $urandom_range(25))));
                3: mac.push_back(8'("0" + $urandom_range(9)));
                default: put_key_name($urandom_range(kmdp_pkg::NKEYS - 1));
            endcase
        end else begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                c = 8'($urandom_range(1, 255));
                mac.push_back((c == " " || c == 8'h09 || c == 8'h22) ? "x" : c);
            end
        end
    endtask

    task automatic put_gap();
        int n;
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) mac.push_back($urandom_range(1) ? " " : 8'h09);
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || in_if.valid || step_q.size() != 0) @(posedge clk);
    endtask

    // Directed macros with their final outcome
    string dir_txt [22] = '{
        "", " \t ", "\"abc", "ctrl+a", "100ms", "\"hi\\\"x\" end", "a+b", "+a", "foo",
        "ctrl+", "shift", "VOL_UP", "F24", "99999ms", "65535MS", "a 0 9 z", "\"\"",
        "ctrl+SHIFT+alt+gui+rctrl+rshift+ralt+rgui+DEL", "averyveryverylongname1",
        "a\x00bc", "lctrl+tab  ", "12m"
    };
    bit         dir_zero [22] = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                  0, 0, 0, 1, 0};
    bit         dir_typed[22] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                                  0, 1, 0, 0, 1};
    logic [2:0] dir_kind [22] = '{kmdp_pkg::KIND_ERROR, kmdp_pkg::KIND_ERROR,
                                  kmdp_pkg::KIND_ERROR, kmdp_pkg::KIND_KEY,
                                  kmdp_pkg::KIND_DELAY, kmdp_pkg::KIND_KEY,
                                  kmdp_pkg::KIND_ERROR, kmdp_pkg::KIND_ERROR,
                                  kmdp_pkg::KIND_ERROR, kmdp_pkg::KIND_KEY,
                                  kmdp_pkg::KIND_KEY, kmdp_pkg::KIND_KEY,
                                  kmdp_pkg::KIND_KEY, kmdp_pkg::KIND_ERROR,
                                  kmdp_pkg::KIND_DELAY, kmdp_pkg::KIND_KEY,
                                  kmdp_pkg::KIND_TEXT, kmdp_pkg::KIND_KEY,
                                  kmdp_pkg::KIND_ERROR, kmdp_pkg::KIND_KEY,
                                  kmdp_pkg::KIND_END, kmdp_pkg::KIND_ERROR};
    logic [2:0] dir_err  [22] = '{kmdp_pkg::ERR_EMPTY, kmdp_pkg::ERR_EMPTY,
                                  kmdp_pkg::ERR_UNTERM, kmdp_pkg::ERR_NONE,
                                  kmdp_pkg::ERR_NONE, kmdp_pkg::ERR_NONE,
                                  kmdp_pkg::ERR_NOT_MOD, kmdp_pkg::ERR_EMPTY_SEG,
                                  kmdp_pkg::ERR_UNKNOWN, kmdp_pkg::ERR_NONE,
                                  kmdp_pkg::ERR_NONE, kmdp_pkg::ERR_NONE,
                                  kmdp_pkg::ERR_NONE, kmdp_pkg::ERR_UNKNOWN,
                                  kmdp_pkg::ERR_NONE, kmdp_pkg::ERR_NONE,
                                  kmdp_pkg::ERR_NONE, kmdp_pkg::ERR_NONE,
                                  kmdp_pkg::ERR_UNKNOWN, kmdp_pkg::ERR_NONE,
                                  kmdp_pkg::ERR_NONE, kmdp_pkg::ERR_UNKNOWN};

    // Main sequence
    initial begin
        int phase_no, rnd_bytes, n_steps;
        idle_pct = 0; stall_pct = 0; hold_req = 1'b0; hold_cnt = 0;
        errors = 0; n_results = 0; n_bytes = 0; n_macros = 0; cycles = 0;
        parser_clear();
        @(posedge rst_n);

        for (int r = 0; r < 22; r++) begin
            put_str(dir_txt[r]);
            if (dir_zero[r]) mac.push_back(8'h00);
            send_macro(dir_typed[r], dir_kind[r], dir_err[r]);
        end
        // One step past the step limit
        for (int i = 0; i <= STEP_LIMIT; i++) put_str("a ");
        send_macro(1'b1, kmdp_pkg::KIND_ERROR, kmdp_pkg::ERR_TOO_MANY);
        wait_drained();

        // Random macros over the idle phases; long hold-off early on
        rnd_bytes = 0;
        phase_no = 0;
        hold_req = 1'b1;
        while (rnd_bytes < RAND_BYTES) begin
            if (rnd_bytes >= (phase_no + 1) * RAND_BYTES / 4) begin
                phase_no++;
                case (phase_no)
                    1: begin idle_pct = 76; stall_pct = 0; end
                    2: begin idle_pct = 0; stall_pct = 76; end
                    default: begin idle_pct = 14; stall_pct = 14; end
                endcase
            end
            if ($urandom_range(1)) put_gap();
            n_steps = ($urandom_range(19) == 0) ? STEP_LIMIT + 2 : $urandom_range(1, 6);
            for (int s = 0; s < n_steps; s++) begin
                put_random_step();
                if (s != n_steps - 1 || $urandom_range(3) == 0) put_gap();
            end
            // Sometimes end by a zero byte, optionally with junk dropped up to the last byte
            if ($urandom_range(4) == 0) begin
                mac.push_back(8'h00);
                repeat ($urandom_range(3)) mac.push_back(8'($urandom_range(255)));
                if ($urandom_range(1)) mac.push_back(8'($urandom_range(255)));
            end
            rnd_bytes += mac.size();
            send_macro(1'b0, kmdp_pkg::KIND_KEY, kmdp_pkg::ERR_NONE);
            while (byte_q.size() > 64) @(posedge clk);
        end
        wait_drained();
        repeat (20) @(posedge clk);

        $display("%0d macros, %0d bytes, %0d results (key %0d delay %0d text %0d error %0d end %0d)",
                 n_macros, n_bytes, n_results, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3], kind_seen[4]);
        $display("error codes seen: %b (code 7 down to 0), mismatches %0d",
                 {err_seen[7], err_seen[6], err_seen[5], err_seen[4], err_seen[3], err_seen[2],
                  err_seen[1], err_seen[0]}, errors);
        if (errors == 0 && step_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
